// ===== rtl/core/uist_pkg.sv =====
// Package for the unique item set table: sizes, field widths, opcodes,
// sequencer states and the structs passed between the core modules.
// No dependencies; every other file of the block imports it.
package uist_pkg;

	// Storage geometry
	localparam int CAPACITY  = 64;
	localparam int ITEM_BITS = 6;
	localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W     = $clog2(CAPACITY + 1);

	// Port field widths
	localparam int OPCODE_W = 2;
	localparam int VALUE_W  = 6;
	localparam int POS_W    = 6;
	localparam int FOUND_W  = 6;
	localparam int COUNT_W  = 7;

	// Remainder unit step counter
	localparam int STEP_W = $clog2(POS_W + 1);

	typedef logic [ITEM_BITS-1:0] item_t;
	typedef logic [IDX_W-1:0]     idx_t;
	typedef logic [CNT_W-1:0]     cnt_t;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_REMOVE = 2'd1,
		OP_LOCATE = 2'd2,
		OP_PICKUP = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MOD,
		ST_SHIFT,
		ST_FIN
	} state_t;

	// Entry store access: one read and one write port
	typedef struct packed {
		idx_t  raddr;
		logic  we;
		idx_t  waddr;
		item_t wdata;
	} mem_req_t;

	// Remainder unit request and answer
	typedef struct packed {
		logic             start;
		logic [POS_W-1:0] dividend;
		cnt_t             divisor;
	} mod_req_t;

	typedef struct packed {
		logic done;
		idx_t rem;
	} mod_rsp_t;

endpackage

// ===== rtl/core/uist_if.sv =====
// Valid/ready channel interfaces for the unique item set table.
// Depends on uist_pkg for field widths.
interface uist_in_if;
	import uist_pkg::*;

	logic               valid;
	logic               ready;
	logic [OPCODE_W-1:0] opcode;
	logic [VALUE_W-1:0]  item_value;
	logic [POS_W-1:0]    position;

	modport source (output valid, output opcode, output item_value, output position,
		input ready);
	modport sink (input valid, input opcode, input item_value, input position,
		output ready);
endinterface

interface uist_out_if;
	import uist_pkg::*;

	logic               valid;
	logic               ready;
	logic               failed;
	logic [FOUND_W-1:0] found_index;
	logic [VALUE_W-1:0] picked_value;
	logic [COUNT_W-1:0] item_count;

	modport source (output valid, output failed, output found_index, output picked_value,
		output item_count, input ready);
	modport sink (input valid, input failed, input found_index, input picked_value,
		input item_count, output ready);
endinterface

// ===== rtl/core/uist_store.sv =====
// Entry store: CAPACITY words of ITEM_BITS, one write and one registered read.
// Depends on uist_pkg for mem_req_t and item_t.
module uist_store (
	input  logic               clk,
	input  uist_pkg::mem_req_t req,
	output uist_pkg::item_t    rdata
);
	import uist_pkg::*;

	item_t mem [CAPACITY];
	item_t rdata_q;

	// Write the addressed entry
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	// Register the read word
	always_ff @(posedge clk) begin
		rdata_q <= mem[req.raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/uist_modu.sv =====
// Iterative remainder unit: position modulo count, one restoring step per cycle.
// Depends on uist_pkg for widths and the mod_req_t / mod_rsp_t structs.
module uist_modu (
	input  logic               clk,
	input  logic               arst_n,
	input  uist_pkg::mod_req_t req,
	output uist_pkg::mod_rsp_t rsp
);
	import uist_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [POS_W-1:0]  dvd_q;
	cnt_t              dvs_q;
	cnt_t              rem_q;
	logic [CNT_W:0]    trial;
	logic              take;

	// Shift in the next dividend bit and compare against the divisor
	assign trial = {rem_q, dvd_q[POS_W-1]};
	assign take  = trial >= {1'b0, dvs_q};

	// Control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(POS_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: partial remainder and dividend shifter
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			rem_q <= take ? CNT_W'(trial - {1'b0, dvs_q}) : CNT_W'(trial);
		end
	end

	assign rsp.done = done_q;
	assign rsp.rem  = rem_q[IDX_W-1:0];

endmodule

// ===== rtl/core/uist_ctrl.sv =====
// Sequencer of the unique item set table: scans and shifts the entry store
// through one compare unit, drives the remainder unit, holds the result word.
// Depends on uist_pkg and the channel interfaces in uist_if.sv.
module uist_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	uist_in_if.sink            in_ch,
	uist_out_if.source         out_ch,
	output uist_pkg::mem_req_t mem_req,
	input  uist_pkg::item_t    mem_rdata,
	output uist_pkg::mod_req_t mod_req,
	input  uist_pkg::mod_rsp_t mod_rsp
);
	import uist_pkg::*;

	state_t state_q, state_d;

	op_t              op_q;
	item_t            item_q;
	cnt_t             cnt_q;
	cnt_t             idx_q;
	logic             pend_q;
	idx_t             pidx_q;
	idx_t             where_q;
	logic             failed_q;
	idx_t             found_q;
	item_t            picked_q;

	logic               ovalid_q;
	logic               ofailed_q;
	logic [FOUND_W-1:0] ofound_q;
	logic [VALUE_W-1:0] opicked_q;
	logic [COUNT_W-1:0] ocount_q;

	logic accept;
	logic issue;
	logic scan_hit;
	logic walk_end;
	logic full;
	logic slot_free;
	logic hold_word;

	assign accept    = in_ch.valid && in_ch.ready;
	assign issue     = idx_q < cnt_q;
	assign scan_hit  = pend_q && (mem_rdata == item_q);
	assign walk_end  = !pend_q && !issue;
	assign full      = cnt_q == CNT_W'(CAPACITY);
	assign slot_free = !ovalid_q || out_ch.ready;
	assign hold_word = pend_q && (pidx_q == where_q);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (op_t'(in_ch.opcode) == OP_PICKUP) begin
						state_d = (cnt_q == '0) ? ST_FIN : ST_MOD;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (scan_hit || walk_end) begin
					state_d = (op_q == OP_REMOVE && scan_hit) ? ST_SHIFT : ST_FIN;
				end
			end
			ST_MOD: begin
				if (mod_rsp.done) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (walk_end) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs to the channel, store and remainder unit
	always_comb begin
		in_ch.ready     = 1'b0;
		mem_req.raddr   = idx_q[IDX_W-1:0];
		mem_req.we      = 1'b0;
		mem_req.waddr   = pidx_q - 1'b1;
		mem_req.wdata   = mem_rdata;
		mod_req.start   = 1'b0;
		mod_req.dividend = in_ch.position;
		mod_req.divisor = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ch.ready   = 1'b1;
				mod_req.start = accept && (op_t'(in_ch.opcode) == OP_PICKUP) && (cnt_q != '0);
			end
			ST_SCAN: begin
				// Append on a clean miss with room left
				if (walk_end && !scan_hit && op_q == OP_INSERT && !full) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = cnt_q[IDX_W-1:0];
					mem_req.wdata = item_q;
				end
			end
			ST_SHIFT: begin
				// Move each later entry down one place
				mem_req.we = pend_q && !hold_word;
			end
			default: begin
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequencer control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			idx_q  <= '0;
			pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					idx_q  <= '0;
					pend_q <= 1'b0;
				end
				ST_SCAN: begin
					pend_q <= issue;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (scan_hit) begin
						idx_q  <= CNT_W'(pidx_q);
						pend_q <= 1'b0;
					end else if (walk_end && op_q == OP_INSERT && !full) begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_MOD: begin
					idx_q  <= CNT_W'(mod_rsp.rem);
					pend_q <= 1'b0;
				end
				ST_SHIFT: begin
					pend_q <= issue;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (walk_end) begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Operand and result datapath
	always_ff @(posedge clk) begin
		pidx_q <= idx_q[IDX_W-1:0];
		unique case (state_q)
			ST_IDLE: begin
				op_q     <= op_t'(in_ch.opcode);
				item_q   <= ITEM_BITS'(in_ch.item_value);
				failed_q <= (op_t'(in_ch.opcode) == OP_PICKUP) && (cnt_q == '0);
				found_q  <= '0;
				picked_q <= '0;
			end
			ST_SCAN: begin
				if (scan_hit) begin
					where_q <= pidx_q;
					if (op_q == OP_LOCATE) begin
						found_q <= pidx_q;
					end
					failed_q <= op_q == OP_INSERT;
				end else if (walk_end) begin
					failed_q <= (op_q != OP_INSERT) || full;
				end
			end
			ST_MOD: begin
				where_q <= mod_rsp.rem;
				found_q <= mod_rsp.rem;
			end
			ST_SHIFT: begin
				// Keep the taken entry on pickup
				if (hold_word && op_q == OP_PICKUP) begin
					picked_q <= mem_rdata;
				end
			end
			default: begin
			end
		endcase
	end

	// Result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (state_q == ST_FIN && slot_free) begin
			ovalid_q <= 1'b1;
		end else if (out_ch.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FIN && slot_free) begin
			ofailed_q <= failed_q;
			ofound_q  <= FOUND_W'(found_q);
			opicked_q <= VALUE_W'(picked_q);
			ocount_q  <= COUNT_W'(cnt_q);
		end
	end

	assign out_ch.valid        = ovalid_q;
	assign out_ch.failed       = ofailed_q;
	assign out_ch.found_index  = ofound_q;
	assign out_ch.picked_value = opicked_q;
	assign out_ch.item_count   = ocount_q;

endmodule

// ===== rtl/core/unique_item_set_table.sv =====
// Top level of the unique item set table: sequencer, entry store, remainder unit.
// Depends on uist_pkg, uist_if.sv, uist_store, uist_modu and uist_ctrl.
//
//   channel  dir  payload                                           accept
//   in_ch    in   opcode, item_value, position                      valid && ready
//   out_ch   out  failed, found_index, picked_value, item_count     valid && ready
//
// Insert, remove and locate scan one entry a cycle; remove and pickup then shift the
// later entries down, and pickup first runs the remainder unit.
// Reset clears the count and the control; the store needs no clearing.
// in_ch.ready is high only while idle; a waiting result word holds the next in ST_FIN.
module unique_item_set_table (
	input  logic      clk,
	input  logic      arst_n,
	uist_in_if.sink   in_ch,
	uist_out_if.source out_ch
);
	import uist_pkg::*;

	mem_req_t mem_req;
	item_t    mem_rdata;
	mod_req_t mod_req;
	mod_rsp_t mod_rsp;

	uist_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.mod_req   (mod_req),
		.mod_rsp   (mod_rsp)
	);

	uist_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

	uist_modu u_modu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mod_req),
		.rsp    (mod_rsp)
	);

endmodule
